### hw/rtl/text_console_cursor_controller_macros.svh
// Assertion macros shared by the text console cursor controller RTL.
`ifndef TEXT_CONSOLE_CURSOR_CONTROLLER_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_CONTROLLER_MACROS_SVH

`ifndef ASSERT_OFF

// expression holds at every clock edge outside reset
`define TCCC_ASSERT(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define TCCC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define TCCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TCCC_ASSERT(label, clk, rst_n, expr, msg)
`define TCCC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define TCCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### hw/rtl/tccc_pkg.sv
// Shared types, constants and codes of the text console cursor controller.
package tccc_pkg;

    // field widths
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int DIM_W    = 10;
    localparam int GLYPH_W  = 6;
    localparam int CODE_W   = 8;
    localparam int COUNT_W  = 9;
    localparam int CUR_W    = 12;
    localparam int POS_W    = 10;
    localparam int LINES_W  = 10;
    localparam int KIND_W   = 2;

    localparam logic [CUR_W-1:0]   CURSOR_MAX = '1;
    localparam logic [LINES_W-1:0] LINES_MAX  = '1;

    // defaults for top level parameters
    localparam int MAX_DIM_DEF   = 1024;
    localparam int OP_DEPTH_DEF  = 2;
    localparam int RES_DEPTH_DEF = 4;

    // commands per item and space steps per tab
    localparam int MAX_RES   = 4;
    localparam int TAB_STEPS = 3;

    // character codes
    localparam logic [CODE_W-1:0] CODE_BS    = 8'd8;
    localparam logic [CODE_W-1:0] CODE_TAB   = 8'd9;
    localparam logic [CODE_W-1:0] CODE_LF    = 8'd10;
    localparam logic [CODE_W-1:0] CODE_CR    = 8'd13;
    localparam logic [CODE_W-1:0] CODE_SPACE = 8'd32;

    // register reset values
    localparam logic [DIM_W-1:0]   RST_SCREEN_WIDTH  = 10'd320;
    localparam logic [DIM_W-1:0]   RST_SCREEN_HEIGHT = 10'd320;
    localparam logic [GLYPH_W-1:0] RST_GLYPH_WIDTH   = 6'd8;
    localparam logic [GLYPH_W-1:0] RST_GLYPH_HEIGHT  = 6'd8;
    localparam logic [DIM_W-1:0]   RST_COLUMNS       = 10'd40;
    localparam logic [CODE_W-1:0]  RST_FIRST_CODE    = 8'd32;
    localparam logic [COUNT_W-1:0] RST_CODE_COUNT    = 9'd95;

    // register indexes
    typedef enum logic [2:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_GLYPH_WIDTH   = 3'd2,
        REG_GLYPH_HEIGHT  = 3'd3,
        REG_COLUMNS       = 3'd4,
        REG_FIRST_CODE    = 3'd5,
        REG_CODE_COUNT    = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [DIM_W-1:0]   screen_width;
        logic [DIM_W-1:0]   screen_height;
        logic [GLYPH_W-1:0] glyph_width;
        logic [GLYPH_W-1:0] glyph_height;
        logic [DIM_W-1:0]   columns;
        logic [CODE_W-1:0]  first_code;
        logic [COUNT_W-1:0] code_count;
    } cfg_t;

    // item classes decided by the front end
    typedef enum logic [2:0] {
        CLS_PRINT,
        CLS_BS,
        CLS_CR,
        CLS_LF,
        CLS_TAB
    } op_cls_t;

    typedef struct packed {
        op_cls_t           cls;
        logic [CODE_W-1:0] code;
        logic              font;        // code lies in the font range
        logic              space_font;  // space lies in the font range
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_GLYPH  = 2'd0,
        KIND_CLEAR  = 2'd1,
        KIND_SCROLL = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [CODE_W-1:0]  glyph_code;
        logic [LINES_W-1:0] scroll_lines;
        logic               last;
    } cmd_t;

    // divider request and response
    typedef struct packed {
        logic               start;
        logic [CUR_W-1:0]   dividend;
        logic [GLYPH_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic odd;
    } div_rsp_t;

endpackage

### hw/rtl/tccc_cfg.sv
// APB register file holding the console geometry and font range.
module tccc_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tccc_pkg::ADDR_W-1:0] paddr,
    input  logic [tccc_pkg::DATA_W-1:0] pwdata,
    output logic [tccc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output tccc_pkg::cfg_t              cfg
);
    import tccc_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_SCREEN_WIDTH:  cfg_next.screen_width  = pwdata[DIM_W-1:0];
                REG_SCREEN_HEIGHT: cfg_next.screen_height = pwdata[DIM_W-1:0];
                REG_GLYPH_WIDTH:   cfg_next.glyph_width   = pwdata[GLYPH_W-1:0];
                REG_GLYPH_HEIGHT:  cfg_next.glyph_height  = pwdata[GLYPH_W-1:0];
                REG_COLUMNS:       cfg_next.columns       = pwdata[DIM_W-1:0];
                REG_FIRST_CODE:    cfg_next.first_code    = pwdata[CODE_W-1:0];
                REG_CODE_COUNT:    cfg_next.code_count    = pwdata[COUNT_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            REG_SCREEN_WIDTH:  prdata = DATA_W'(cfg_reg.screen_width);
            REG_SCREEN_HEIGHT: prdata = DATA_W'(cfg_reg.screen_height);
            REG_GLYPH_WIDTH:   prdata = DATA_W'(cfg_reg.glyph_width);
            REG_GLYPH_HEIGHT:  prdata = DATA_W'(cfg_reg.glyph_height);
            REG_COLUMNS:       prdata = DATA_W'(cfg_reg.columns);
            REG_FIRST_CODE:    prdata = DATA_W'(cfg_reg.first_code);
            REG_CODE_COUNT:    prdata = DATA_W'(cfg_reg.code_count);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width  <= RST_SCREEN_WIDTH;
            cfg_reg.screen_height <= RST_SCREEN_HEIGHT;
            cfg_reg.glyph_width   <= RST_GLYPH_WIDTH;
            cfg_reg.glyph_height  <= RST_GLYPH_HEIGHT;
            cfg_reg.columns       <= RST_COLUMNS;
            cfg_reg.first_code    <= RST_FIRST_CODE;
            cfg_reg.code_count    <= RST_CODE_COUNT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hw/rtl/tccc_front.sv
// Front end: classifies incoming characters and checks the font range.
module tccc_front (
    input  logic                        push,
    input  logic [tccc_pkg::CODE_W-1:0] char_code,
    input  tccc_pkg::cfg_t              cfg,
    input  logic                        op_full,
    output logic                        op_push,
    output tccc_pkg::op_t               op
);
    import tccc_pkg::*;

    localparam int SUM_W = COUNT_W + 1;

    logic [SUM_W-1:0] font_end;

    // font range is first_code .. first_code + code_count - 1
    assign font_end      = SUM_W'(cfg.first_code) + SUM_W'(cfg.code_count);
    assign op.code       = char_code;
    assign op.font       = (char_code >= cfg.first_code) &&
                           (SUM_W'(char_code) < font_end);
    assign op.space_font = (CODE_SPACE >= cfg.first_code) &&
                           (SUM_W'(CODE_SPACE) < font_end);
    assign op_push       = push && !op_full;

    // control code decode
    always_comb
    begin
        unique case (char_code)
            CODE_BS:  op.cls = CLS_BS;
            CODE_CR:  op.cls = CLS_CR;
            CODE_LF:  op.cls = CLS_LF;
            CODE_TAB: op.cls = CLS_TAB;
            default:  op.cls = CLS_PRINT;
        endcase
    end

endmodule

### hw/rtl/tccc_fifo.sv
// Small register queue used between the front end, back end and result port.
module tccc_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_push;
    logic          do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### hw/rtl/tccc_div.sv
// Restoring divider, one quotient bit per cycle; reports quotient parity.
module tccc_div (
    input  logic               clk,
    input  logic               rst_n,
    input  tccc_pkg::div_req_t req,
    output tccc_pkg::div_rsp_t rsp
);
    import tccc_pkg::*;

    localparam int ITER  = CUR_W;
    localparam int CNT_W = $clog2(ITER + 1);
    localparam int REM_W = GLYPH_W + 1;

    logic [CUR_W-1:0]   work_reg;
    logic [GLYPH_W-1:0] rem_reg;
    logic [GLYPH_W-1:0] dvs_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [REM_W-1:0]   trial;
    logic [REM_W-1:0]   diff;
    logic               fits;

    // one restoring step
    assign trial = {rem_reg, work_reg[CUR_W-1]};
    assign fits  = (trial >= REM_W'(dvs_reg));
    assign diff  = trial - REM_W'(dvs_reg);

    assign rsp.done = done_reg;
    assign rsp.odd  = work_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ITER);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            work_reg <= req.dividend;
            rem_reg  <= '0;
            dvs_reg  <= req.divisor;
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[CUR_W-2:0], fits};
            rem_reg  <= fits ? diff[GLYPH_W-1:0] : trial[GLYPH_W-1:0];
        end
    end

endmodule

### hw/rtl/tccc_back.sv
// Back end: moves the cursor and generates draw and scroll commands.
`include "text_console_cursor_controller_macros.svh"

module tccc_back #(
    parameter int MAX_DIM = tccc_pkg::MAX_DIM_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tccc_pkg::cfg_t     cfg,
    input  logic               op_empty,
    input  tccc_pkg::op_t      op_in,
    output logic               op_pop,
    input  logic               res_full,
    output logic               res_push,
    output tccc_pkg::cmd_t     res_data,
    output tccc_pkg::div_req_t div_req,
    input  tccc_pkg::div_rsp_t div_rsp
);
    import tccc_pkg::*;

    localparam int CNT_W = $clog2(MAX_RES + 1);
    localparam int TY_W  = CUR_W + 1;
    localparam int LF_W  = CUR_W + 2;
    localparam int PRD_W = DIM_W + GLYPH_W;
    localparam logic [CUR_W-1:0] POS_LIM = CUR_W'(MAX_DIM - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRAP,
        S_LF,
        S_LF2,
        S_BS,
        S_PRINT,
        S_DIV,
        S_END
    } state_t;

    state_t           state_reg, state_next;
    op_t              op_reg, op_next;
    logic             tab_reg, tab_next;
    logic             lfw_reg, lfw_next;
    logic [1:0]       steps_reg, steps_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    cmd_t             pend_reg, pend_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [CUR_W-1:0] cx_reg, cx_next;
    logic [CUR_W-1:0] cy_reg, cy_next;
    logic [TY_W-1:0]  ty_reg, ty_next;

    logic             can_emit;
    logic             emit_req;
    cmd_t             emit_cmd;

    // dispatch after the wrap check
    state_t           disp_state;
    logic             disp_tab;
    logic             disp_cx0;

    // datapath helpers
    logic             wrap_over;
    logic             wrap_flag;
    logic [LF_W-1:0]  lf_u;
    logic [LF_W-1:0]  lf_n;
    logic             lf_over;
    logic [LINES_W-1:0] lf_lines;
    logic [CUR_W-1:0] lf_top;
    logic [CUR_W-1:0] ty_sat;
    logic             bs_borrow;
    logic [CUR_W-1:0] bs_y;
    logic [DIM_W-1:0] cols_m1;
    logic [PRD_W-1:0] bs_prod;
    logic [CUR_W-1:0] bs_wrap_x;
    logic [TY_W-1:0]  adv;
    logic [CUR_W-1:0] adv_sat;
    logic [CUR_W-1:0] px_lim;
    logic [CUR_W-1:0] py_lim;
    logic             pr_font;
    logic [CODE_W-1:0] pr_code;
    logic [1:0]       steps_inc;
    logic             tab_more;

    // wrap check: cell would pass the right edge
    assign wrap_flag = tab_reg ? op_reg.space_font : op_reg.font;
    assign wrap_over = (TY_W'(cx_reg) + TY_W'(cfg.glyph_width)) > TY_W'(cfg.screen_width);

    // line feed, second half: scroll by the excess
    assign lf_u     = LF_W'(ty_reg) + LF_W'(cfg.glyph_height);
    assign lf_over  = lf_u >= LF_W'(cfg.screen_height);
    assign lf_n     = lf_u - LF_W'(cfg.screen_height);
    assign lf_lines = (lf_n > LF_W'(LINES_MAX)) ? LINES_MAX : lf_n[LINES_W-1:0];
    assign lf_top   = (cfg.screen_height >= DIM_W'(cfg.glyph_height)) ?
                      CUR_W'(cfg.screen_height - DIM_W'(cfg.glyph_height)) : '0;
    assign ty_sat   = (ty_reg > TY_W'(CURSOR_MAX)) ? CURSOR_MAX : ty_reg[CUR_W-1:0];

    // backspace
    assign bs_borrow = cx_reg < CUR_W'(cfg.glyph_width);
    assign bs_y      = (cy_reg >= CUR_W'(cfg.glyph_height)) ?
                       cy_reg - CUR_W'(cfg.glyph_height) : '0;
    assign cols_m1   = cfg.columns - 1'b1;
    assign bs_prod   = PRD_W'(cols_m1) * PRD_W'(cfg.glyph_width);
    assign bs_wrap_x = (cfg.columns == '0) ? '0 :
                       (bs_prod > PRD_W'(CURSOR_MAX)) ? CURSOR_MAX : bs_prod[CUR_W-1:0];

    // print cell
    assign adv       = TY_W'(cx_reg) + TY_W'(cfg.glyph_width);
    assign adv_sat   = (adv > TY_W'(CURSOR_MAX)) ? CURSOR_MAX : adv[CUR_W-1:0];
    assign px_lim    = (cx_reg > POS_LIM) ? POS_LIM : cx_reg;
    assign py_lim    = (cy_reg > POS_LIM) ? POS_LIM : cy_reg;
    assign pr_font   = tab_reg ? op_reg.space_font : op_reg.font;
    assign pr_code   = tab_reg ? CODE_SPACE : op_reg.code;
    assign steps_inc = steps_reg + 1'b1;
    assign tab_more  = (steps_inc < 2'(TAB_STEPS)) && (cfg.glyph_width != '0);

    // a new command may be taken unless it would push into a full queue
    assign can_emit = (cnt_reg == CNT_W'(MAX_RES)) || !pend_valid_reg || !res_full;

    // where an item goes once the wrap check is through
    always_comb
    begin
        disp_state = S_PRINT;
        disp_tab   = tab_reg;
        disp_cx0   = 1'b0;
        if (!tab_reg)
        begin
            unique case (op_reg.cls)
                CLS_BS:
                begin
                    disp_state = S_BS;
                end
                CLS_CR:
                begin
                    disp_state = S_END;
                    disp_cx0   = 1'b1;
                end
                CLS_LF:
                begin
                    disp_state = S_LF;
                end
                CLS_TAB:
                begin
                    // every space gets its own wrap check, the first one too
                    disp_state = S_WRAP;
                    disp_tab   = 1'b1;
                end
                default:
                begin
                    disp_state = S_PRINT;
                end
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        tab_next        = tab_reg;
        lfw_next        = lfw_reg;
        steps_next      = steps_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        ty_next         = ty_reg;
        op_pop          = 1'b0;
        res_push        = 1'b0;
        res_data        = pend_reg;
        res_data.last   = 1'b0;
        emit_req        = 1'b0;
        emit_cmd        = '0;
        div_req         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!op_empty)
                begin
                    op_pop     = 1'b1;
                    op_next    = op_in;
                    tab_next   = 1'b0;
                    steps_next = '0;
                    cnt_next   = '0;
                    state_next = S_WRAP;
                end
            end
            S_WRAP:
            begin
                if (wrap_flag && wrap_over)
                begin
                    cx_next    = '0;
                    lfw_next   = 1'b1;
                    state_next = S_LF;
                end
                else
                begin
                    lfw_next   = 1'b0;
                    tab_next   = disp_tab;
                    state_next = disp_state;
                    if (disp_cx0)
                    begin
                        cx_next = '0;
                    end
                end
            end
            S_LF:
            begin
                cx_next    = '0;
                ty_next    = TY_W'(cy_reg) + TY_W'(cfg.glyph_height);
                state_next = S_LF2;
            end
            S_LF2:
            begin
                if (!(lf_over && (lf_n != '0) && !can_emit))
                begin
                    if (lf_over)
                    begin
                        cy_next = lf_top;
                        if (lf_n != '0)
                        begin
                            emit_req              = 1'b1;
                            emit_cmd.kind         = KIND_SCROLL;
                            emit_cmd.scroll_lines = lf_lines;
                        end
                    end
                    else
                    begin
                        cy_next = ty_sat;
                    end
                    if (lfw_reg)
                    begin
                        lfw_next   = 1'b0;
                        tab_next   = disp_tab;
                        state_next = disp_state;
                        if (disp_cx0)
                        begin
                            cx_next = '0;
                        end
                    end
                    else
                    begin
                        state_next = S_END;
                    end
                end
            end
            S_BS:
            begin
                if (bs_borrow)
                begin
                    cy_next = bs_y;
                    cx_next = bs_wrap_x;
                end
                else
                begin
                    cx_next = cx_reg - CUR_W'(cfg.glyph_width);
                end
                state_next = S_END;
            end
            S_PRINT:
            begin
                if (can_emit)
                begin
                    emit_req          = 1'b1;
                    emit_cmd.kind     = pr_font ? KIND_GLYPH : KIND_CLEAR;
                    emit_cmd.pos_x    = px_lim[POS_W-1:0];
                    emit_cmd.pos_y    = py_lim[POS_W-1:0];
                    emit_cmd.glyph_code = pr_font ? pr_code : '0;
                    cx_next           = adv_sat;
                    state_next        = S_END;
                    if (tab_reg)
                    begin
                        steps_next = steps_inc;
                        if (tab_more)
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = adv_sat;
                            div_req.divisor  = cfg.glyph_width;
                            state_next       = S_DIV;
                        end
                    end
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = div_rsp.odd ? S_WRAP : S_END;
                end
            end
            S_END:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!res_full)
                begin
                    res_push        = 1'b1;
                    res_data.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // hold the newest command back until it is known whether it is the last
        if (emit_req && (cnt_reg < CNT_W'(MAX_RES)))
        begin
            if (pend_valid_reg)
            begin
                res_push = 1'b1;
            end
            pend_next       = emit_cmd;
            pend_valid_next = 1'b1;
            cnt_next        = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tab_reg        <= 1'b0;
            lfw_reg        <= 1'b0;
            steps_reg      <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            cx_reg         <= '0;
            cy_reg         <= '0;
            ty_reg         <= '0;
            op_reg         <= '0;
            pend_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            tab_reg        <= tab_next;
            lfw_reg        <= lfw_next;
            steps_reg      <= steps_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            cx_reg         <= cx_next;
            cy_reg         <= cy_next;
            ty_reg         <= ty_next;
            op_reg         <= op_next;
            pend_reg       <= pend_next;
        end
    end

    // checks
    `TCCC_ASSERT(a_res_no_overflow, clk, rst_n, !(res_push && res_full), "result push into full queue")
    `TCCC_ASSERT(a_cnt_range, clk, rst_n, cnt_reg <= CNT_W'(MAX_RES), "command count out of range")
    `TCCC_ASSERT_IMP(a_div_nonzero, clk, rst_n, div_req.start, cfg.glyph_width != '0, "divide by zero width")
    `TCCC_ASSERT_IMP(a_div_wait, clk, rst_n, div_rsp.done, state_reg == S_DIV, "divider done outside wait")
    `TCCC_ASSERT_NEXT(a_end_flush, clk, rst_n, (state_reg == S_END) && !res_full, (state_reg == S_IDLE) && !pend_valid_reg, "item end did not flush")

endmodule

### hw/rtl/text_console_cursor_controller.sv
// Top level of the text console cursor controller.
//
//  channel   direction  handshake             payload
//  input     in         push / full           char_code
//  result    out        pop / empty           kind pos_x pos_y glyph_code scroll_lines last
//  config    in         APB psel/penable      paddr pwdata prdata (registers at 4*i)
//
// A character passes fetch and wrap check, then its own states and flush: print for a
// printable, backspace, none for return, both line-feed states for line feed (a wrap adds
// them too). A tab then takes per space a wrap check, a print and, while more may follow,
// the 12-step parity divider, and flush at the end.
// Reset puts registers at their defaults, the cursor at 0,0 and empties both queues.
// A full result queue stalls the back end; a full op queue raises full.
module text_console_cursor_controller #(
    parameter int MAX_DIM   = tccc_pkg::MAX_DIM_DEF,
    parameter int OP_DEPTH  = tccc_pkg::OP_DEPTH_DEF,
    parameter int RES_DEPTH = tccc_pkg::RES_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tccc_pkg::ADDR_W-1:0]  paddr,
    input  logic [tccc_pkg::DATA_W-1:0]  pwdata,
    output logic [tccc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         push,
    output logic                         full,
    input  logic [tccc_pkg::CODE_W-1:0]  char_code,
    output logic                         empty,
    input  logic                         pop,
    output logic [tccc_pkg::KIND_W-1:0]  kind,
    output logic [tccc_pkg::POS_W-1:0]   pos_x,
    output logic [tccc_pkg::POS_W-1:0]   pos_y,
    output logic [tccc_pkg::CODE_W-1:0]  glyph_code,
    output logic [tccc_pkg::LINES_W-1:0] scroll_lines,
    output logic                         last
);
    import tccc_pkg::*;

    cfg_t     cfg;
    op_t      op_wr;
    op_t      op_rd;
    logic     op_push;
    logic     op_pop;
    logic     op_empty;
    cmd_t     res_wr;
    cmd_t     res_rd;
    logic     res_push;
    logic     res_full;
    div_req_t div_req;
    div_rsp_t div_rsp;

    tccc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tccc_front u_front (
        .push      (push),
        .char_code (char_code),
        .cfg       (cfg),
        .op_full   (full),
        .op_push   (op_push),
        .op        (op_wr)
    );

    tccc_fifo #(
        .W     ($bits(op_t)),
        .DEPTH (OP_DEPTH)
    ) u_op_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (op_push),
        .wdata (op_wr),
        .full  (full),
        .pop   (op_pop),
        .rdata (op_rd),
        .empty (op_empty)
    );

    tccc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    tccc_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .op_empty (op_empty),
        .op_in    (op_rd),
        .op_pop   (op_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res_data (res_wr),
        .div_req  (div_req),
        .div_rsp  (div_rsp)
    );

    tccc_fifo #(
        .W     ($bits(cmd_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wr),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rd),
        .empty (empty)
    );

    // result fields
    assign kind         = res_rd.kind;
    assign pos_x        = res_rd.pos_x;
    assign pos_y        = res_rd.pos_y;
    assign glyph_code   = res_rd.glyph_code;
    assign scroll_lines = res_rd.scroll_lines;
    assign last         = res_rd.last;

endmodule

### dv/text_console_cursor_controller_test.sv
// Testbench for the text console cursor controller: predicts draw commands and checks them.
`timescale 1ns / 1ps

import tccc_pkg::*;

// Tracks the cursor and configuration, expands each character into the commands it causes
class cursor_tracker;
    localparam int MAX_POS = MAX_DIM_DEF - 1;

    cfg_t cfg;
    int   cur_x;
    int   cur_y;
    cmd_t step_cmds[$];
    cmd_t cmds_due[$];
    int   errors;

    function new();
        cfg.screen_width  = RST_SCREEN_WIDTH;
        cfg.screen_height = RST_SCREEN_HEIGHT;
        cfg.glyph_width   = RST_GLYPH_WIDTH;
        cfg.glyph_height  = RST_GLYPH_HEIGHT;
        cfg.columns       = RST_COLUMNS;
        cfg.first_code    = RST_FIRST_CODE;
        cfg.code_count    = RST_CODE_COUNT;
        cur_x  = 0;
        cur_y  = 0;
        errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, int unsigned value);
        case (idx)
            REG_SCREEN_WIDTH:  cfg.screen_width  = value[DIM_W-1:0];
            REG_SCREEN_HEIGHT: cfg.screen_height = value[DIM_W-1:0];
            REG_GLYPH_WIDTH:   cfg.glyph_width   = value[GLYPH_W-1:0];
            REG_GLYPH_HEIGHT:  cfg.glyph_height  = value[GLYPH_W-1:0];
            REG_COLUMNS:       cfg.columns       = value[DIM_W-1:0];
            REG_FIRST_CODE:    cfg.first_code    = value[CODE_W-1:0];
            REG_CODE_COUNT:    cfg.code_count    = value[COUNT_W-1:0];
            default: ;
        endcase
    endfunction

    function bit busy();
        return cmds_due.size() != 0;
    endfunction

    function int clamp_cursor(int v);
        if (v < 0)
            return 0;
        if (v > int'(CURSOR_MAX))
            return int'(CURSOR_MAX);
        return v;
    endfunction

    function bit in_font(int code);
        int first;
        int count;
        first = cfg.first_code;
        count = cfg.code_count;
        return code >= first && code < first + count;
    endfunction

    // commands past the per-item limit are dropped, the cursor still moves
    function void add_cmd(kind_t k, int x, int y, int g, int n);
        cmd_t c;
        if (step_cmds.size() >= MAX_RES)
            return;
        c.kind         = k;
        c.pos_x        = POS_W'(x);
        c.pos_y        = POS_W'(y);
        c.glyph_code   = CODE_W'(g);
        c.scroll_lines = LINES_W'(n);
        c.last         = 1'b0;
        step_cmds.push_back(c);
    endfunction

    // new line, scrolling by the overhang when the next row does not fit
    function void line_feed();
        int gh;
        int sh;
        int t;
        gh = cfg.glyph_height;
        sh = cfg.screen_height;
        t  = cur_y + gh;
        cur_x = 0;
        if (t + gh >= sh)
        begin
            if (t + gh - sh > 0)
                add_cmd(KIND_SCROLL, 0, 0, 0, (t + gh - sh > 1023) ? 1023 : t + gh - sh);
            t = sh - gh;
        end
        cur_y = clamp_cursor(t);
    endfunction

    function void wrap_check(int code);
        int gw;
        int sw;
        gw = cfg.glyph_width;
        sw = cfg.screen_width;
        if (in_font(code) && cur_x + gw > sw)
        begin
            cur_x = 0;
            line_feed();
        end
    endfunction

    function void print_cell(int code);
        int px;
        int py;
        int gw;
        gw = cfg.glyph_width;
        px = (cur_x > MAX_POS) ? MAX_POS : cur_x;
        py = (cur_y > MAX_POS) ? MAX_POS : cur_y;
        if (in_font(code))
            add_cmd(KIND_GLYPH, px, py, code, 0);
        else
            add_cmd(KIND_CLEAR, px, py, 0, 0);
        cur_x = clamp_cursor(cur_x + gw);
    endfunction

    // accepted character: work out the commands it causes
    function void take_char(logic [CODE_W-1:0] code);
        int   steps;
        int   x;
        int   gw;
        int   gh;
        int   cols;
        cmd_t c;
        gw   = cfg.glyph_width;
        gh   = cfg.glyph_height;
        cols = cfg.columns;
        step_cmds.delete();
        wrap_check(int'(code));
        case (code)
            CODE_BS:
            begin
                x = cur_x - gw;
                if (x < 0)
                begin
                    cur_y = clamp_cursor(cur_y - gh);
                    x = (cols - 1) * gw;
                end
                cur_x = clamp_cursor(x);
            end
            CODE_CR:
                cur_x = 0;
            CODE_LF:
                line_feed();
            CODE_TAB:
            begin
                // spaces until the column is even, at most TAB_STEPS; zero width counts as even
                steps = 0;
                do
                begin
                    wrap_check(int'(CODE_SPACE));
                    print_cell(int'(CODE_SPACE));
                    steps++;
                end
                while (steps < TAB_STEPS && gw != 0 && ((cur_x / gw) % 2) != 0);
            end
            default:
                print_cell(int'(code));
        endcase
        for (int i = 0; i < step_cmds.size(); i++)
        begin
            c = step_cmds[i];
            c.last = (i == step_cmds.size() - 1);
            cmds_due.push_back(c);
        end
    endfunction

    function string show_cmd(cmd_t c);
        return $sformatf("kind=%0d x=%0d y=%0d glyph=%0d lines=%0d last=%0d",
                         c.kind, c.pos_x, c.pos_y, c.glyph_code, c.scroll_lines, c.last);
    endfunction

    function void flag(string msg);
        errors++;
        if (errors <= 10)
            $display("ERROR %0t: %s", $time, msg);
    endfunction

    // accepted command: compare with the oldest prediction
    function void check_cmd(cmd_t got);
        cmd_t want;
        if (cmds_due.size() == 0)
        begin
            flag($sformatf("command with none due: %s", show_cmd(got)));
            return;
        end
        want = cmds_due.pop_front();
        if (got.kind !== want.kind || got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
            got.glyph_code !== want.glyph_code || got.scroll_lines !== want.scroll_lines ||
            got.last !== want.last)
            flag($sformatf("want %s / got %s", show_cmd(want), show_cmd(got)));
    endfunction
endclass

module text_console_cursor_controller_test;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 200;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 38;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 psel         = 1'b0;
    logic                 penable      = 1'b0;
    logic                 pwrite       = 1'b0;
    logic [ADDR_W-1:0]    paddr        = '0;
    logic [DATA_W-1:0]    pwdata       = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 push         = 1'b0;
    logic                 full;
    logic [CODE_W-1:0]    char_code    = '0;
    logic                 empty;
    logic                 pop          = 1'b0;
    logic [KIND_W-1:0]    kind;
    logic [POS_W-1:0]     pos_x;
    logic [POS_W-1:0]     pos_y;
    logic [CODE_W-1:0]    glyph_code;
    logic [LINES_W-1:0]   scroll_lines;
    logic                 last;

    cursor_tracker tracker = new();
    bit            calm = 1'b0;
    int            stall_cycles = 0;

    // default font: field extremes, font edges, backspace and return, edge wrap
    logic [CODE_W-1:0] opening_chars [12] = '{
        8'h00, 8'hFF, 8'd65, CODE_SPACE, 8'd126, 8'd127, 8'd31,
        CODE_BS, CODE_CR, CODE_BS, 8'd87, 8'd88
    };

    // narrow screen: tab across the wrap, scroll, backspace up a line
    logic [CODE_W-1:0] narrow_chars [13] = '{
        8'd97, 8'd98, CODE_TAB, CODE_LF, CODE_LF, 8'd99, CODE_BS,
        CODE_BS, CODE_BS, CODE_CR, 8'd113, 8'd114, 8'd115
    };

    text_console_cursor_controller DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .push         (push),
        .full         (full),
        .char_code    (char_code),
        .empty        (empty),
        .pop          (pop),
        .kind         (kind),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .glyph_code   (glyph_code),
        .scroll_lines (scroll_lines),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // handshake monitor, checker and watchdog
    always @(posedge clk)
    begin : monitor
        bit   moved;
        cmd_t got;
        if (rst_n)
        begin
            moved = 1'b0;
            if (push && !full)
            begin
                tracker.take_char(char_code);
                moved = 1'b1;
            end
            if (pop && !empty)
            begin
                got.kind         = kind_t'(kind);
                got.pos_x        = pos_x;
                got.pos_y        = pos_y;
                got.glyph_code   = glyph_code;
                got.scroll_lines = scroll_lines;
                got.last         = last;
                tracker.check_cmd(got);
                moved = 1'b1;
            end
            if (moved || !(push || tracker.busy()))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // result side: random stall bursts, none once calm
    initial
    begin : drain
        wait (rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            pop <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    task automatic send_char(input logic [CODE_W-1:0] c);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        push      <= 1'b1;
        char_code <= c;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    // wait for all due commands, then let any silent item finish
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (tracker.busy()) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        tracker.set_reg(idx, value);
    endtask

    task automatic program_regs(input cfg_t c);
        write_reg(REG_SCREEN_WIDTH,  c.screen_width);
        write_reg(REG_SCREEN_HEIGHT, c.screen_height);
        write_reg(REG_GLYPH_WIDTH,   c.glyph_width);
        write_reg(REG_GLYPH_HEIGHT,  c.glyph_height);
        write_reg(REG_COLUMNS,       c.columns);
        write_reg(REG_FIRST_CODE,    c.first_code);
        write_reg(REG_CODE_COUNT,    c.code_count);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic cfg_t make_cfg(int phase);
        cfg_t c;
        int   gw;
        int   gh;
        int   sw;
        int   sh;
        case (phase)
            // largest screen and columns, whole code space in the font
            0: c = '{10'd1023, 10'd1023, 6'd32, 6'd32, 10'd1023, 8'd0, 9'd256};
            // smallest screen, empty font
            1: c = '{10'd1, 10'd1, 6'd1, 6'd1, 10'd1, 8'd255, 9'd0};
            // zero-size cells, font count at field max
            2: c = '{10'd40, 10'd30, 6'd0, 6'd0, 10'd0, 8'd200, 9'd511};
            // oversized cells, control codes inside the font
            3: c = '{10'd100, 10'd200, 6'd63, 6'd63, 10'd2, 8'd8, 9'd6};
            // single font code at the top of the byte range
            4: c = '{10'd64, 10'd48, 6'd8, 6'd16, 10'd8, 8'd255, 9'd1};
            default:
            begin
                gw = $urandom_range(1, 32);
                gh = $urandom_range(1, 32);
                sw = $urandom_range(gw, gw * 12);
                sh = $urandom_range(gh, gh * 10);
                if (sw > 1023)
                    sw = 1023;
                if (sh > 1023)
                    sh = 1023;
                c.screen_width  = DIM_W'(sw);
                c.screen_height = DIM_W'(sh);
                c.glyph_width   = GLYPH_W'(gw);
                c.glyph_height  = GLYPH_W'(gh);
                c.columns       = DIM_W'(sw / gw);
                c.first_code    = CODE_W'($urandom_range(0, 255));
                c.code_count    = COUNT_W'($urandom_range(0, 256));
            end
        endcase
        return c;
    endfunction

    // mostly font codes and control codes, some raw bytes
    function automatic logic [CODE_W-1:0] pick_char();
        int first;
        int count;
        first = tracker.cfg.first_code;
        count = tracker.cfg.code_count;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
                if (count > 0)
                    return CODE_W'(first + $urandom_range(0, count - 1));
                else
                    return CODE_W'($urandom_range(0, 255));
            4: return CODE_BS;
            5: return CODE_LF;
            6: return CODE_TAB;
            7: return ($urandom_range(0, 1) != 0) ? CODE_CR : CODE_SPACE;
            default: return CODE_W'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin : stimulus
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_chars[i])
            send_char(opening_chars[i]);
        settle();

        program_regs('{10'd20, 10'd24, 6'd8, 6'd8, 10'd3, 8'd32, 9'd95});
        foreach (narrow_chars[i])
            send_char(narrow_chars[i]);
        settle();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            program_regs(make_cfg(p));
            calm = (p == RAND_PHASES - 1);
            repeat (PHASE_ITEMS) send_char(pick_char());
            settle();
        end

        if (tracker.errors == 0 && !tracker.busy())
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

### files.f
+incdir+hw/rtl
hw/rtl/tccc_pkg.sv
hw/rtl/tccc_cfg.sv
hw/rtl/tccc_front.sv
hw/rtl/tccc_fifo.sv
hw/rtl/tccc_div.sv
hw/rtl/tccc_back.sv
hw/rtl/text_console_cursor_controller.sv
dv/text_console_cursor_controller_test.sv
